// ----- rtl/frbe_pkg.sv -----
`timescale 1ns / 1ps

package frbe_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int OFF_W  = 32;
    localparam int CFG_W  = 6;

    // reset value of the block size register
    localparam logic [CFG_W-1:0] BLK_SIZE_RST = 6'd32;

    // result tdata layout, lowest bit first
    localparam int FILL_LSB   = 0;
    localparam int LEN_LSB    = FILL_LSB + BYTE_W;
    localparam int OFF_LSB    = LEN_LSB + LEN_W;
    localparam int PBYTE_LSB  = OFF_LSB + OFF_W;
    localparam int M_FIELDS_W = PBYTE_LSB + BYTE_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // result tuser layout
    localparam int USER_DESC = 0;
    localparam int USER_KIND = 1;
    localparam int M_USER_W  = 2;

    // descriptor kinds
    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_RAW  = 1'b1;

endpackage

// ----- rtl/fill_raw_block_encoder_top.sv -----
`timescale 1ns / 1ps

// Channel  | Dir | Signals                          | Content
// ---------+-----+----------------------------------+------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata s_tlast| one chunk byte, tlast = chunk end
// m_       | out | m_tvalid m_tready m_tdata m_tuser| descriptor or raw payload byte,
//          |     | m_tlast                          | tlast = last result of the input
// cfg_     | in  | cfg_valid cfg_ready cfg_data     | block size write
//
// Input bytes are accepted one per cycle while filling and the output register is
// free. A closing byte puts its descriptor in the output register at its own
// transfer; a raw block then drains from the block memory through the registered
// read port, one byte per cycle while m_tready stays high, with the input held off.
// Reset (aresetn low, synchronous) clears control state only, not the block memory.
// m_tready low stalls the output register and, behind it, the drain and the input.

module fill_raw_block_encoder_top #(
    parameter int MAX_BLOCK = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // s_tdata: [7:0] data_byte
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [frbe_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                           s_tlast,

    // m_tdata: [7:0] fill_byte, [13:8] block_length, [45:14] payload_offset,
    //          [53:46] payload_byte, [55:54] zero
    // m_tuser: [0] is_descriptor, [1] block_kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [frbe_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [frbe_pkg::M_USER_W-1:0]  m_tuser,
    output logic                           m_tlast,

    // block size register
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [frbe_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam logic [frbe_pkg::LEN_W-1:0] MAX_LEN = frbe_pkg::LEN_W'(MAX_BLOCK);

    // sequencer states
    localparam logic ST_IN    = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    // block memory: written while filling, read while draining
    logic [frbe_pkg::BYTE_W-1:0] block_mem [MAX_BLOCK];
    logic [frbe_pkg::BYTE_W-1:0] mem_q_reg;

    logic                         state_reg, state_next;
    logic [frbe_pkg::CFG_W-1:0]   size_cfg_reg;
    logic [frbe_pkg::LEN_W-1:0]   count_reg, count_next;
    logic [frbe_pkg::BYTE_W-1:0]  first_reg, first_next;
    logic                         uniform_reg, uniform_next;
    logic [frbe_pkg::OFF_W-1:0]   offset_reg, offset_next;

    // drain control
    logic [frbe_pkg::LEN_W-1:0]   drain_len_reg, drain_len_next;
    logic [frbe_pkg::LEN_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                         q_valid_reg, q_valid_next;   // mem_q_reg holds a byte
    logic                         q_last_reg, q_last_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [frbe_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [frbe_pkg::M_USER_W-1:0] m_user_reg, m_user_next;
    logic                         m_last_reg, m_last_next;

    logic                         out_free;
    logic                         s_xfer;
    logic [frbe_pkg::LEN_W-1:0]   size_eff;
    logic [frbe_pkg::LEN_W-1:0]   count_inc;
    logic                         uniform_now;
    logic [frbe_pkg::BYTE_W-1:0]  first_now;
    logic                         closing;
    logic                         q_load;
    logic                         rd_issue;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IN) && out_free;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // zero acts as one, anything over the memory depth as the depth
    always_comb begin
        if (size_cfg_reg == '0) begin
            size_eff = frbe_pkg::LEN_W'(1);
        end else if (size_cfg_reg > MAX_LEN) begin
            size_eff = MAX_LEN;
        end else begin
            size_eff = size_cfg_reg;
        end
    end

    assign count_inc   = count_reg + frbe_pkg::LEN_W'(1);
    assign first_now   = (count_reg == '0) ? s_tdata : first_reg;
    assign uniform_now = (count_reg == '0) ? 1'b1 : (uniform_reg && (s_tdata == first_reg));
    assign closing     = (count_inc >= size_eff) || s_tlast;

    // drain: byte in mem_q moves to the output register when it frees up,
    // and a new read is issued while bytes remain and mem_q is empty or being emptied
    assign q_load   = (state_reg == ST_DRAIN) && q_valid_reg && out_free;
    assign rd_issue = (state_reg == ST_DRAIN) && (rd_idx_reg < drain_len_reg)
                      && (!q_valid_reg || q_load);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        uniform_next   = uniform_reg;
        offset_next    = offset_reg;
        drain_len_next = drain_len_reg;
        rd_idx_next    = rd_idx_reg;
        q_valid_next   = q_valid_reg;
        q_last_next    = q_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;

        if (s_xfer) begin
            first_next   = first_now;
            uniform_next = uniform_now;
            count_next   = count_inc;
            if (closing) begin
                count_next   = '0;
                uniform_next = 1'b1;
                m_valid_next = 1'b1;
                m_data_next  = '0;
                m_data_next[frbe_pkg::LEN_LSB +: frbe_pkg::LEN_W] = count_inc;
                m_data_next[frbe_pkg::OFF_LSB +: frbe_pkg::OFF_W] = offset_reg;
                m_user_next[frbe_pkg::USER_DESC] = 1'b1;
                if (uniform_now) begin
                    m_data_next[frbe_pkg::FILL_LSB +: frbe_pkg::BYTE_W] = first_now;
                    m_user_next[frbe_pkg::USER_KIND] = frbe_pkg::KIND_FILL;
                    m_last_next = 1'b1;
                end else begin
                    m_user_next[frbe_pkg::USER_KIND] = frbe_pkg::KIND_RAW;
                    m_last_next    = 1'b0;
                    offset_next    = offset_reg + frbe_pkg::OFF_W'(count_inc);
                    state_next     = ST_DRAIN;
                    drain_len_next = count_inc;
                    rd_idx_next    = '0;
                    q_valid_next   = 1'b0;
                end
                if (s_tlast) begin
                    offset_next = '0;
                end
            end
        end

        if (q_load) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[frbe_pkg::PBYTE_LSB +: frbe_pkg::BYTE_W] = mem_q_reg;
            m_user_next  = '0;
            m_last_next  = q_last_reg;
            q_valid_next = 1'b0;
            if (q_last_reg) begin
                state_next = ST_IN;
            end
        end

        if (rd_issue) begin
            q_valid_next = 1'b1;
            q_last_next  = (rd_idx_reg == drain_len_reg - frbe_pkg::LEN_W'(1));
            rd_idx_next  = rd_idx_reg + frbe_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IN;
            size_cfg_reg   <= frbe_pkg::BLK_SIZE_RST;
            count_reg      <= '0;
            first_reg      <= '0;
            uniform_reg    <= 1'b1;
            offset_reg     <= '0;
            drain_len_reg  <= '0;
            rd_idx_reg     <= '0;
            q_valid_reg    <= 1'b0;
            q_last_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready) begin
                size_cfg_reg <= cfg_data;
            end
            count_reg     <= count_next;
            first_reg     <= first_next;
            uniform_reg   <= uniform_next;
            offset_reg    <= offset_next;
            drain_len_reg <= drain_len_next;
            rd_idx_reg    <= rd_idx_next;
            q_valid_reg   <= q_valid_next;
            q_last_reg    <= q_last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload of the output register
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    // block memory, one write port (fill) and one registered read port (drain)
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            block_mem[count_reg[AW-1:0]] <= s_tdata;
        end
        if (rd_issue) begin
            mem_q_reg <= block_mem[rd_idx_reg[AW-1:0]];
        end
    end

endmodule

// ----- rtl/frbe_checker.sv -----
`timescale 1ns / 1ps

module frbe_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [frbe_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [frbe_pkg::M_USER_W-1:0]  m_tuser
,   input logic                           m_tlast
);

    // a fill descriptor is always the only result of its input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[frbe_pkg::USER_DESC]
        && (m_tuser[frbe_pkg::USER_KIND] == frbe_pkg::KIND_FILL) |-> m_tlast)
        else $error("fill descriptor without tlast");

    // a raw descriptor is always followed by payload bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[frbe_pkg::USER_DESC]
        && (m_tuser[frbe_pkg::USER_KIND] == frbe_pkg::KIND_RAW) |-> !m_tlast)
        else $error("raw descriptor marked last");

    // descriptors never carry an empty block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[frbe_pkg::USER_DESC]
        |-> (m_tdata[frbe_pkg::LEN_LSB +: frbe_pkg::LEN_W] != '0))
        else $error("descriptor with zero length");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind fill_raw_block_encoder_top frbe_checker u_frbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- test/tb_fill_raw_block_encoder_top.sv -----
`timescale 1ns / 1ps

module tb_fill_raw_block_encoder_top;

    localparam int BYTE_W   = frbe_pkg::BYTE_W;
    localparam int LEN_W    = frbe_pkg::LEN_W;
    localparam int OFF_W    = frbe_pkg::OFF_W;
    localparam int CFG_W    = frbe_pkg::CFG_W;
    localparam int M_DATA_W = frbe_pkg::M_DATA_W;
    localparam int M_USER_W = frbe_pkg::M_USER_W;

    localparam int BLOCK_MAX      = 32;
    localparam int SETTLE_CYCLES  = 8;     // covers output reg + read data reg
    localparam int HOLD_CYCLES    = 300;   // long sink hold-off for backpressure
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer

    // byte pattern of a generated chunk
    typedef enum int {
        FILL_RUN,    // one value throughout
        NEAR_FILL,   // one value with occasional stray bytes
        RAW_NOISE    // independent random bytes
    } chunk_shape_t;

    // one encoder output transfer
    typedef struct {
        logic              desc;
        logic              kind;
        logic [BYTE_W-1:0] fill;
        logic [LEN_W-1:0]  len;
        logic [OFF_W-1:0]  off;
        logic [BYTE_W-1:0] pbyte;
        logic              last;
    } enc_result_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;

    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic                 s_tlast   = 1'b0;

    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0]  m_tuser;
    logic                 m_tlast;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // mirror of the encoder state
    logic [BYTE_W-1:0]    blk_buf [BLOCK_MAX];
    int                   blk_len;
    logic [BYTE_W-1:0]    blk_fill;
    bit                   blk_same;
    logic [OFF_W-1:0]     raw_offset;
    logic [CFG_W-1:0]     blk_size_reg;

    enc_result_t          due_results[$];   // outputs predicted, not yet seen
    int                   err_cnt      = 0;
    int                   quiet_cycles = 0;

    // idling / pressure knobs
    bit                   s_idle_en  = 1'b0;
    bit                   m_idle_en  = 1'b0;
    int                   hold_asked = 0;   // bumped by a test to request a hold-off
    int                   hold_taken = 0;
    int                   hold_left  = 0;

    fill_raw_block_encoder_top #(
        .MAX_BLOCK (BLOCK_MAX)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // register value -> size actually used: 0 acts as 1, above max clamps
    function automatic int eff_size(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > BLOCK_MAX)
            return BLOCK_MAX;
        return int'(v);
    endfunction

    function automatic void clear_encoder_state();
        blk_len      = 0;
        blk_fill     = '0;
        blk_same     = 1'b1;
        raw_offset   = '0;
        blk_size_reg = frbe_pkg::BLK_SIZE_RST;
    endfunction

    // Feed one accepted byte; queue every output transfer it causes.
    function automatic void encode_byte(logic [BYTE_W-1:0] b, bit chunk_end);
        enc_result_t r;
        int size;
        size = eff_size(blk_size_reg);
        if (blk_len < BLOCK_MAX)
            blk_buf[blk_len] = b;
        if (blk_len == 0) begin
            blk_fill = b;
            blk_same = 1'b1;
        end else if (b != blk_fill) begin
            blk_same = 1'b0;
        end
        blk_len++;
        if (blk_len < size && !chunk_end)
            return;

        // block closes: descriptor first
        r.desc  = 1'b1;
        r.kind  = blk_same ? frbe_pkg::KIND_FILL : frbe_pkg::KIND_RAW;
        r.fill  = blk_same ? blk_fill : '0;
        r.len   = LEN_W'(blk_len);
        r.off   = raw_offset;
        r.pbyte = '0;
        r.last  = blk_same;
        due_results.insert(due_results.size(), r);

        // raw block: buffered bytes follow, one transfer each
        if (!blk_same) begin
            for (int i = 0; i < blk_len && i < BLOCK_MAX; i++) begin
                r.desc  = 1'b0;
                r.kind  = 1'b0;
                r.fill  = '0;
                r.len   = '0;
                r.off   = '0;
                r.pbyte = blk_buf[i];
                r.last  = (i == blk_len - 1);
                due_results.insert(due_results.size(), r);
            end
            raw_offset = raw_offset + OFF_W'(blk_len);
        end

        blk_len  = 0;
        blk_same = 1'b1;
        if (chunk_end)
            raw_offset = '0;
    endfunction

    // ------------------------------------------------------------------
    // Output side: sink ready, checker, watchdog
    // ------------------------------------------------------------------

    // Sink ready: random stalls when enabled; a requested hold-off is
    // counted down here so the sender keeps offering meanwhile.
    always @(posedge aclk) begin
        if (hold_taken != hold_asked) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = hold_asked;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(m_idle_en && $urandom_range(0, 99) < 7);
        end
    end

    function automatic void compare_field(string name, logic [OFF_W-1:0] want_v,
                                          logic [OFF_W-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, actual %0h", name, want_v, got_v);
            err_cnt++;
        end
    endfunction

    // Every output transfer is matched against the oldest prediction.
    always @(posedge aclk) begin
        enc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $error("output transfer with nothing predicted (tuser %0h tdata %0h)",
                       m_tuser, m_tdata);
                err_cnt++;
            end else begin
                want = due_results.pop_front();
                compare_field("is_descriptor",  want.desc,
                              m_tuser[frbe_pkg::USER_DESC]);
                compare_field("block_kind",     want.kind,
                              m_tuser[frbe_pkg::USER_KIND]);
                compare_field("fill_byte",      want.fill,
                              m_tdata[frbe_pkg::FILL_LSB +: BYTE_W]);
                compare_field("block_length",   want.len,
                              m_tdata[frbe_pkg::LEN_LSB +: LEN_W]);
                compare_field("payload_offset", want.off,
                              m_tdata[frbe_pkg::OFF_LSB +: OFF_W]);
                compare_field("payload_byte",   want.pbyte,
                              m_tdata[frbe_pkg::PBYTE_LSB +: BYTE_W]);
                compare_field("last_of_run",    want.last,  m_tlast);
            end
        end
    end

    // Watchdog: too long without any transfer on any channel ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_fill_raw_block_encoder_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte and wait for its transfer; valid stays up afterwards
    // so back-to-back bytes go out without a bubble.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit chunk_end);
        if (s_idle_en && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= chunk_end;
        do @(posedge aclk); while (!s_tready);
        encode_byte(b, chunk_end);
    endtask

    // Stop offering, let every predicted output arrive, then give the
    // pipeline time to finish any work that produces nothing.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called while idle (after settle).
    task automatic set_blk_size(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        blk_size_reg = v;
    endtask

    task automatic send_chunk(input int n, input chunk_shape_t shape, input bit close);
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] b;
        base = BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < n; i++) begin
            case (shape)
                FILL_RUN:  b = base;
                NEAR_FILL: b = ($urandom_range(0, 99) < 10) ?
                               BYTE_W'($urandom_range(0, 255)) : base;
                default:   b = BYTE_W'($urandom_range(0, 255));
            endcase
            push_byte(b, close && (i == n - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size (32): chunk end closes short blocks; offset restarts per chunk.
    task automatic test_reset_size();
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);    // raw, 3 bytes
        push_byte(8'hFF, 1'b1);    // single-byte fill
    endtask

    // Size register extremes: 0 acts as 1, 63 clamps to the max.
    task automatic test_size_limits();
        settle();
        set_blk_size(6'd0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h00, 1'b1);
        settle();
        set_blk_size(6'd63);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);
        settle();
        set_blk_size(6'd1);
        push_byte(8'h3C, 1'b1);
    endtask

    // Size shrinks while a block is half full: the next byte closes it.
    task automatic test_mid_block_resize();
        settle();
        set_blk_size(6'd2);
        push_byte(8'h11, 1'b0);
        push_byte(8'h11, 1'b0);    // fill
        push_byte(8'h12, 1'b0);
        push_byte(8'h13, 1'b0);    // raw, offset 0
        push_byte(8'h14, 1'b0);    // left open
        settle();
        set_blk_size(6'd1);
        push_byte(8'h14, 1'b0);    // count passes new size: fill of 2
        settle();
        set_blk_size(6'd4);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        settle();
        set_blk_size(6'd2);
        push_byte(8'h04, 1'b1);    // raw of 4 at offset 2, chunk done
    endtask

    // Sink holds off for a long stretch while bytes keep coming.
    task automatic test_backpressure();
        settle();
        set_blk_size(6'd4);
        hold_asked++;
        send_chunk(24, RAW_NOISE, 1'b1);
    endtask

    // Random phases: new size, then a few chunks of mixed shape. Some
    // chunks stay open so the next size change lands mid-block.
    task automatic test_random_stream(input int n_items);
        int sent;
        int n;
        int eff;
        int cap;
        logic [CFG_W-1:0] v;
        sent = 0;
        while (sent < n_items) begin
            settle();
            case ($urandom_range(0, 9))
                0:       v = 6'd0;
                1:       v = 6'd1;
                2:       v = 6'd32;
                3:       v = 6'd63;
                4:       v = CFG_W'($urandom_range(33, 62));
                5:       v = CFG_W'($urandom_range(16, 31));
                default: v = CFG_W'($urandom_range(2, 8));
            endcase
            set_blk_size(v);
            eff = eff_size(v);
            repeat ($urandom_range(1, 3)) begin
                if (sent < n_items) begin
                    cap = (2 * eff + 2 < 40) ? 2 * eff + 2 : 40;
                    if (cap > n_items - sent)
                        cap = n_items - sent;
                    n = $urandom_range(1, cap);
                    send_chunk(n, chunk_shape_t'($urandom_range(0, 2)),
                               $urandom_range(0, 5) != 0);
                    sent += n;
                end
            end
        end
    endtask

    initial begin
        clear_encoder_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        s_idle_en = 1'b1;
        m_idle_en = 1'b1;

        test_reset_size();
        test_size_limits();
        test_mid_block_resize();
        test_backpressure();
        test_random_stream(56);

        // full-rate stretch, both sides always ready
        s_idle_en = 1'b0;
        m_idle_en = 1'b0;
        test_random_stream(30);

        settle();
        repeat (2 * BLOCK_MAX) @(posedge aclk);   // catch stray outputs
        if (err_cnt == 0)
            $display("tb_fill_raw_block_encoder_top: clean");
        else
            $display("tb_fill_raw_block_encoder_top: errors");
        $finish;
    end

endmodule
